/* rtl/jsu_pkg.sv */
// Shared types and constants of the JSON string unescape block.
package jsu_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_BODY = 2'd1,
      MODE_ESC  = 2'd2,
      MODE_HEX  = 2'd3
   } mode_type;

   // Results caused by one input byte: one to three bytes, or one bare end marker.
   typedef struct packed {
      logic [1:0]      last_idx;
      logic            has_byte;
      logic            done;
      logic [2:0][7:0] bytes;
   } group_type;

   localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
   localparam logic [7:0]  UTF8_CONT      = 8'h80;
   localparam logic [7:0]  UTF8_CONT_MASK = 8'h3F;
   localparam logic [15:0] CP_ONE_BYTE    = 16'h0080;
   localparam logic [15:0] CP_TWO_BYTE    = 16'h0800;

endpackage

/* rtl/jsu_front.sv */
// Front end: decode state machine that turns each byte into a result group.
module jsu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        in_byte,
   input  logic              start_flag,
   input  logic              end_of_buffer,
   output logic              grp_write,
   output jsu_pkg::group_type grp_data
);

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U = 8'h75;
   localparam logic [7:0] CH_B = 8'h62;
   localparam logic [7:0] CH_F = 8'h66;
   localparam logic [7:0] CH_N = 8'h6E;
   localparam logic [7:0] CH_R = 8'h72;
   localparam logic [7:0] CH_T = 8'h74;
   localparam logic [7:0] ASCII_BS = 8'h08;
   localparam logic [7:0] ASCII_FF = 8'h0C;
   localparam logic [7:0] ASCII_LF = 8'h0A;
   localparam logic [7:0] ASCII_CR = 8'h0D;
   localparam logic [7:0] ASCII_HT = 8'h09;

   jsu_pkg::mode_type mode_ff, mode_in;
   logic [1:0]        hex_cnt_ff, hex_cnt_in;
   logic [15:0]       cp_ff, cp_in;
   logic [15:0]       cp_next;
   logic              emit;
   logic              done;

   function automatic logic [3:0] hex_value(input logic [7:0] h);
      logic [3:0] v;
      v = 4'd0;
      if (h >= 8'h30 && h <= 8'h39) begin
         v = h[3:0];
      end else if ((h >= 8'h61 && h <= 8'h66) || (h >= 8'h41 && h <= 8'h46)) begin
         v = 4'(h[3:0] + 4'd9);
      end
      return v;
   endfunction

   function automatic logic [7:0] escape_map(input logic [7:0] e);
      logic [7:0] r;
      unique case (e)
         CH_B:    r = ASCII_BS;
         CH_F:    r = ASCII_FF;
         CH_N:    r = ASCII_LF;
         CH_R:    r = ASCII_CR;
         CH_T:    r = ASCII_HT;
         default: r = e;
      endcase
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= jsu_pkg::MODE_IDLE;
         hex_cnt_ff <= 2'd0;
         cp_ff      <= 16'd0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         hex_cnt_ff <= hex_cnt_in;
         cp_ff      <= cp_in;
      end
   end

   assign cp_next = {cp_ff[11:0], hex_value(in_byte)};

   always_comb begin
      mode_in           = mode_ff;
      hex_cnt_in        = hex_cnt_ff;
      cp_in             = cp_ff;
      emit              = 1'b0;
      done              = 1'b0;
      grp_data.last_idx = 2'd0;
      grp_data.has_byte = 1'b0;
      grp_data.bytes    = '0;
      if (start_flag) begin
         hex_cnt_in = 2'd0;
         cp_in      = 16'd0;
         if (in_byte != CH_QUOTE) begin
            done = 1'b1;
         end else begin
            mode_in = jsu_pkg::MODE_BODY;
            done    = end_of_buffer;
         end
      end else begin
         unique case (mode_ff)
            jsu_pkg::MODE_IDLE: begin
               // drop stray bytes outside a string
            end
            jsu_pkg::MODE_BODY: begin
               if (in_byte == CH_QUOTE) begin
                  done = 1'b1;
               end else if (in_byte == CH_BSLASH) begin
                  mode_in = jsu_pkg::MODE_ESC;
                  done    = end_of_buffer;
               end else begin
                  emit              = 1'b1;
                  grp_data.has_byte = 1'b1;
                  grp_data.bytes[0] = in_byte;
                  done              = end_of_buffer;
               end
            end
            jsu_pkg::MODE_ESC: begin
               done = end_of_buffer;
               if (in_byte == CH_U) begin
                  mode_in    = jsu_pkg::MODE_HEX;
                  hex_cnt_in = 2'd0;
                  cp_in      = 16'd0;
               end else begin
                  mode_in           = jsu_pkg::MODE_BODY;
                  emit              = 1'b1;
                  grp_data.has_byte = 1'b1;
                  grp_data.bytes[0] = escape_map(in_byte);
               end
            end
            jsu_pkg::MODE_HEX: begin
               cp_in = cp_next;
               done  = end_of_buffer;
               if (hex_cnt_ff != 2'd3) begin
                  hex_cnt_in = 2'(hex_cnt_ff + 2'd1);
               end else begin
                  hex_cnt_in        = 2'd0;
                  mode_in           = jsu_pkg::MODE_BODY;
                  emit              = 1'b1;
                  grp_data.has_byte = 1'b1;
                  if (cp_next < jsu_pkg::CP_ONE_BYTE) begin
                     grp_data.bytes[0] = cp_next[7:0];
                  end else if (cp_next < jsu_pkg::CP_TWO_BYTE) begin
                     grp_data.last_idx = 2'd1;
                     grp_data.bytes[0] = jsu_pkg::UTF8_LEAD2 | {3'd0, cp_next[10:6]};
                     grp_data.bytes[1] = jsu_pkg::UTF8_CONT |
                                         (cp_next[7:0] & jsu_pkg::UTF8_CONT_MASK);
                  end else begin
                     grp_data.last_idx = 2'd2;
                     grp_data.bytes[0] = jsu_pkg::UTF8_LEAD3 | {4'd0, cp_next[15:12]};
                     grp_data.bytes[1] = jsu_pkg::UTF8_CONT |
                                         (cp_next[13:6] & jsu_pkg::UTF8_CONT_MASK);
                     grp_data.bytes[2] = jsu_pkg::UTF8_CONT |
                                         (cp_next[7:0] & jsu_pkg::UTF8_CONT_MASK);
                  end
               end
            end
            default: begin
            end
         endcase
      end
      // a finished string always returns to idle
      if (done) begin
         mode_in = jsu_pkg::MODE_IDLE;
      end
      grp_data.done = done;
      grp_write     = accept && (emit || done);
   end

endmodule

/* rtl/jsu_queue.sv */
// Short queue of result groups between the decoder and the output stage.
module jsu_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  jsu_pkg::group_type wr_data,
   output logic               full,
   input  logic               rd_en,
   output logic               rd_valid,
   output jsu_pkg::group_type rd_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   jsu_pkg::group_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr;
   logic               do_rd;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_wr && !do_rd) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_rd && !do_wr) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* rtl/jsu_back.sv */
// Back end: unloads result groups into the output register, one result per cycle while it is free or popped.
module jsu_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               grp_valid,
   input  jsu_pkg::group_type grp_data,
   output logic               grp_pop,
   output logic               empty,
   input  logic               pop,
   output logic [7:0]         out_byte,
   output logic               has_byte,
   output logic               run_last,
   output logic               string_done
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       has_ff;
   logic       last_ff;
   logic       done_ff;
   logic       load;
   logic       at_end;

   assign load    = grp_valid && (!valid_ff || pop);
   assign at_end  = (idx_ff == grp_data.last_idx);
   assign grp_pop = load && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = at_end ? 2'd0 : 2'(idx_ff + 2'd1);
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= grp_data.bytes[idx_ff];
         has_ff  <= grp_data.has_byte;
         last_ff <= at_end;
         done_ff <= at_end && grp_data.done;
      end
   end

   assign empty       = !valid_ff;
   assign out_byte    = byte_ff;
   assign has_byte    = has_ff;
   assign run_last    = last_ff;
   assign string_done = done_ff;

endmodule

/* rtl/json_string_unescape.sv */
// JSON string unescape: one raw byte per cycle in, decoded UTF-8 bytes out.
// The input side accepts a byte every cycle while req_full is low; the decoder
// turns it at once into a group of zero to three results (a \u escape on its
// fourth hex digit yields up to three bytes) and writes the group into a queue
// of QUEUE_DEPTH groups. The output stage delivers one result per cycle from
// that queue while its register is free or popped; a result passes through
// the queue and the output register to the rsp_ ports, and the queue keeps
// taking groups while a result waits at the output. req_full rises only when
// the queue is full, which happens only while the consumer holds off rsp_pop.
module json_string_unescape #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_start_flag,
   input  logic       req_end_of_buffer,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic       rsp_run_last,
   output logic       rsp_string_done
);

   logic               accept;
   logic               grp_write;
   jsu_pkg::group_type grp_wr_data;
   logic               grp_valid;
   jsu_pkg::group_type grp_rd_data;
   logic               grp_pop;

   assign accept = req_push && !req_full;

   jsu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_byte       (req_in_byte),
      .start_flag    (req_start_flag),
      .end_of_buffer (req_end_of_buffer),
      .grp_write     (grp_write),
      .grp_data      (grp_wr_data)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (grp_write),
      .wr_data  (grp_wr_data),
      .full     (req_full),
      .rd_en    (grp_pop),
      .rd_valid (grp_valid),
      .rd_data  (grp_rd_data)
   );

   jsu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .grp_valid   (grp_valid),
      .grp_data    (grp_rd_data),
      .grp_pop     (grp_pop),
      .empty       (rsp_empty),
      .pop         (rsp_pop),
      .out_byte    (rsp_out_byte),
      .has_byte    (rsp_has_byte),
      .run_last    (rsp_run_last),
      .string_done (rsp_string_done)
   );

endmodule

/* rtl/jsu_checker.sv */
// Port-level checks of the JSON string unescape block and their binding.
module jsu_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_has_byte,
   input logic       rsp_run_last,
   input logic       rsp_string_done
);

   // nothing left over from before reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending right after reset");

   // an end of string always closes the results of its byte
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_string_done) |-> rsp_run_last)
      else $error("string end not on last result of its byte");

   // a bare marker exists only to end a string
   a_marker_done: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_has_byte) |-> (rsp_string_done && rsp_run_last))
      else $error("bare marker that does not end a string");

   // hold a waiting result until its transaction completes
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_byte)
                                    && $stable(rsp_has_byte) && $stable(rsp_run_last)
                                    && $stable(rsp_string_done)))
      else $error("waiting result changed before pop");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_has_byte    (rsp_has_byte),
   .rsp_run_last    (rsp_run_last),
   .rsp_string_done (rsp_string_done)
);

/* bench/jsu_checker.sv */
// Checker for the JSON string unescape block: predicts decoded results and compares them.
module jsu_scoreboard (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_start_flag,
   input  logic       req_end_of_buffer,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_has_byte,
   input  logic       rsp_run_last,
   input  logic       rsp_string_done,
   output int         mismatches,
   output int         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CTRL_BS      = 8'h08;
   localparam logic [7:0] CTRL_FF      = 8'h0C;
   localparam logic [7:0] CTRL_LF      = 8'h0A;
   localparam logic [7:0] CTRL_CR      = 8'h0D;
   localparam logic [7:0] CTRL_TAB     = 8'h09;

   typedef struct packed {
      logic [7:0] data;
      logic       has;
      logic       last;
      logic       done;
   } decoded_type;

   decoded_type       awaited_bytes[$];
   jsu_pkg::mode_type mode = jsu_pkg::MODE_IDLE;
   logic [1:0]        digits = '0;
   logic [15:0]       code = '0;

   function automatic decoded_type plain_byte(input logic [7:0] b);
      decoded_type d;
      d = '0;
      d.data = b;
      d.has = 1'b1;
      return d;
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9")
         return c[3:0];
      if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
         return c[3:0] + 4'd9;
      return 4'd0;
   endfunction

   function automatic logic [7:0] escape_char(input logic [7:0] e);
      unique case (e)
         CH_B:    return CTRL_BS;
         CH_F:    return CTRL_FF;
         CH_N:    return CTRL_LF;
         CH_R:    return CTRL_CR;
         CH_T:    return CTRL_TAB;
         default: return e;
      endcase
   endfunction

   // Advance the decoder by one accepted byte and queue the results it causes.
   function automatic void decode_byte(input logic [7:0] b, input logic start, input logic eob);
      decoded_type grp[$];
      logic        done;
      done = 1'b0;
      if (start) begin
         digits = '0;
         code = '0;
         if (b != CH_QUOTE) begin
            mode = jsu_pkg::MODE_IDLE;
            done = 1'b1;
         end else begin
            mode = jsu_pkg::MODE_BODY;
            done = eob;
         end
      end else begin
         unique case (mode)
            jsu_pkg::MODE_IDLE: return;
            jsu_pkg::MODE_BODY: begin
               if (b == CH_QUOTE) begin
                  done = 1'b1;
               end else if (b == CH_BACKSLASH) begin
                  mode = jsu_pkg::MODE_ESC;
                  done = eob;
               end else begin
                  grp.insert(grp.size(), plain_byte(b));
                  done = eob;
               end
            end
            jsu_pkg::MODE_ESC: begin
               if (b == CH_U) begin
                  mode = jsu_pkg::MODE_HEX;
                  digits = '0;
                  code = '0;
               end else begin
                  mode = jsu_pkg::MODE_BODY;
                  grp.insert(grp.size(), plain_byte(escape_char(b)));
               end
               done = eob;
            end
            jsu_pkg::MODE_HEX: begin
               code = {code[11:0], hex_nibble(b)};
               if (digits != 2'd3) begin
                  digits = digits + 2'd1;
               end else begin
                  digits = '0;
                  mode = jsu_pkg::MODE_BODY;
                  if (code < jsu_pkg::CP_ONE_BYTE) begin
                     grp.insert(grp.size(), plain_byte(code[7:0]));
                  end else if (code < jsu_pkg::CP_TWO_BYTE) begin
                     grp.insert(grp.size(),
                                plain_byte(jsu_pkg::UTF8_LEAD2 | {3'b000, code[10:6]}));
                     grp.insert(grp.size(),
                                plain_byte(jsu_pkg::UTF8_CONT | {2'b00, code[5:0]}));
                  end else begin
                     grp.insert(grp.size(),
                                plain_byte(jsu_pkg::UTF8_LEAD3 | {4'b0000, code[15:12]}));
                     grp.insert(grp.size(),
                                plain_byte(jsu_pkg::UTF8_CONT | {2'b00, code[11:6]}));
                     grp.insert(grp.size(),
                                plain_byte(jsu_pkg::UTF8_CONT | {2'b00, code[5:0]}));
                  end
               end
               done = eob;
            end
         endcase
      end
      // A string that ends without a decoded byte still reports a bare end marker.
      if (done && grp.size() == 0)
         grp.insert(0, decoded_type'(0));
      if (grp.size() > 0) begin
         grp[grp.size() - 1].last = 1'b1;
         grp[grp.size() - 1].done = done;
      end
      if (done)
         mode = jsu_pkg::MODE_IDLE;
      foreach (grp[i])
         awaited_bytes.insert(awaited_bytes.size(), grp[i]);
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      decoded_type want;
      if (reset) begin
         awaited_bytes.delete();
         mode = jsu_pkg::MODE_IDLE;
         digits = '0;
         code = '0;
      end else begin
         if (req_push && !req_full)
            decode_byte(req_in_byte, req_start_flag, req_end_of_buffer);
         if (rsp_pop && !rsp_empty) begin
            if (awaited_bytes.size() == 0) begin
               $error("unexpected transaction: out_byte %0h has_byte %0b", rsp_out_byte,
                      rsp_has_byte);
               mismatches++;
            end else begin
               want = awaited_bytes.pop_front();
               check_field("out_byte", want.data, rsp_out_byte);
               check_field("has_byte", want.has, rsp_has_byte);
               check_field("run_last", want.last, rsp_run_last);
               check_field("string_done", want.done, rsp_string_done);
            end
         end
      end
      pending = awaited_bytes.size();
   end

endmodule

/* bench/json_string_unescape_tb.sv */
// Testbench top for the JSON string unescape block: stimulus, flow control and verdict.
module json_string_unescape_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam int         RANDOM_ITEMS = 90;
   localparam int         CALM_TAIL    = 20;
   localparam int         HOLD_CYCLES  = 50;
   localparam int         DRAIN_CYCLES = 8;
   localparam int         STALL_LIMIT  = 1000;

   typedef struct packed {
      logic [7:0] data;
      logic       start;
      logic       eob;
   } raw_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_in_byte = '0;
   logic       req_start_flag = 1'b0;
   logic       req_end_of_buffer = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_has_byte;
   logic       rsp_run_last;
   logic       rsp_string_done;
   int         mismatches;
   int         pending;

   raw_type stream[$];
   int      ignored_items = 0;
   int      idle_cycles = 0;
   logic    gaps_on = 1'b1;
   logic    calm = 1'b0;
   logic    hold_request = 1'b0;

   always #5 clock = ~clock;

   json_string_unescape uut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_in_byte       (req_in_byte),
      .req_start_flag    (req_start_flag),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_has_byte      (rsp_has_byte),
      .rsp_run_last      (rsp_run_last),
      .rsp_string_done   (rsp_string_done)
   );

   jsu_scoreboard unescape_check (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_in_byte       (req_in_byte),
      .req_start_flag    (req_start_flag),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_has_byte      (rsp_has_byte),
      .rsp_run_last      (rsp_run_last),
      .rsp_string_done   (rsp_string_done),
      .mismatches        (mismatches),
      .pending           (pending)
   );

   function automatic void put_raw(input logic [7:0] b, input logic start, input logic eob);
      raw_type r;
      r.data = b;
      r.start = start;
      r.eob = eob;
      stream.insert(stream.size(), r);
   endfunction

   function automatic logic [7:0] hex_glyph(input logic [3:0] v);
      if (v < 4'd10)
         return "0" + v;
      return ($urandom_range(0, 1) ? "A" : "a") + v - 8'd10;
   endfunction

   // Append a \u escape; when cut is set, stop after kept digits and end the buffer there.
   function automatic void add_unicode(input int kept, input logic cut);
      logic [15:0] value;
      logic [7:0]  glyph;
      case ($urandom_range(0, 3))
         0: value = 16'($urandom_range(0, 16'h7F));
         1: value = 16'($urandom_range(16'h80, 16'h7FF));
         2: value = 16'($urandom_range(16'h800, 16'hFFFF));
         default: begin
            case ($urandom_range(0, 4))
               0: value = 16'h0000;
               1: value = 16'h007F;
               2: value = 16'h0080;
               3: value = 16'h07FF;
               default: value = 16'h0800;
            endcase
         end
      endcase
      put_raw(CH_BACKSLASH, 1'b0, 1'b0);
      put_raw(CH_U, 1'b0, cut && kept == 0);
      for (int i = 0; i < kept; i++) begin
         glyph = hex_glyph(value[15 - 4 * i -: 4]);
         // non-hex letters decode as zero
         if ($urandom_range(0, 11) == 0)
            glyph = 8'("g" + $urandom_range(0, 19));
         put_raw(glyph, 1'b0, cut && i == kept - 1);
      end
   endfunction

   function automatic void add_simple_escape();
      logic [7:0] e;
      case ($urandom_range(0, 8))
         0: e = CH_QUOTE;
         1: e = CH_BACKSLASH;
         2: e = "/";
         3: e = "b";
         4: e = "f";
         5: e = "n";
         6: e = "r";
         7: e = "t";
         default: begin
            e = 8'($urandom_range(0, 255));
            if (e == CH_U)
               e = "v";
         end
      endcase
      put_raw(CH_BACKSLASH, 1'b0, 1'b0);
      put_raw(e, 1'b0, 1'b0);
   endfunction

   function automatic void build_directed();
      // ignored while idle, with and without buffer end
      put_raw("x", 1'b0, 1'b0);
      put_raw(8'hFF, 1'b0, 1'b1);
      ignored_items = 2;
      put_raw(8'h00, 1'b1, 1'b0);
      put_raw(CH_QUOTE, 1'b1, 1'b1);
      put_raw(CH_QUOTE, 1'b1, 1'b0);
      put_raw(8'hFF, 1'b0, 1'b0);
      put_raw(CH_BACKSLASH, 1'b0, 1'b0);
      put_raw("t", 1'b0, 1'b0);
      put_raw(CH_BACKSLASH, 1'b0, 1'b0);
      put_raw("/", 1'b0, 1'b0);
      put_raw(CH_BACKSLASH, 1'b0, 1'b0);
      put_raw(CH_U, 1'b0, 1'b0);
      put_raw("F", 1'b0, 1'b0);
      put_raw("f", 1'b0, 1'b0);
      put_raw("F", 1'b0, 1'b0);
      put_raw("F", 1'b0, 1'b0);
      put_raw(CH_QUOTE, 1'b0, 1'b0);
      // restart in the middle of an escape, then end the buffer on a plain byte
      put_raw(CH_QUOTE, 1'b1, 1'b0);
      put_raw(CH_BACKSLASH, 1'b0, 1'b0);
      put_raw(CH_QUOTE, 1'b1, 1'b0);
      put_raw("q", 1'b0, 1'b1);
      put_raw(CH_QUOTE, 1'b1, 1'b0);
      put_raw(CH_BACKSLASH, 1'b0, 1'b1);
      put_raw(CH_QUOTE, 1'b1, 1'b0);
      put_raw(CH_BACKSLASH, 1'b0, 1'b0);
      put_raw(CH_U, 1'b0, 1'b0);
      put_raw("7", 1'b0, 1'b1);
   endfunction

   function automatic void build_random();
      int         first;
      logic [7:0] b;
      logic       start;
      first = stream.size();
      while (stream.size() - first - ignored_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            start = 1'($urandom_range(0, 1));
            put_raw(8'($urandom_range(0, 255)), start, 1'($urandom_range(0, 1)));
            if (!start)
               ignored_items++;
         end else begin
            put_raw(CH_QUOTE, 1'b1, 1'b0);
            repeat ($urandom_range(0, 5)) begin
               case ($urandom_range(0, 3))
                  0, 1: begin
                     b = 8'($urandom_range(0, 255));
                     if (b == CH_QUOTE || b == CH_BACKSLASH)
                        b = b ^ 8'h01;
                     put_raw(b, 1'b0, 1'b0);
                  end
                  2: add_simple_escape();
                  default: add_unicode(4, 1'b0);
               endcase
            end
            case ($urandom_range(0, 7))
               0, 1, 2, 3: put_raw(CH_QUOTE, 1'b0, $urandom_range(0, 3) == 0);
               4: stream[stream.size() - 1].eob = 1'b1;
               5: begin
                  if ($urandom_range(0, 1))
                     add_unicode($urandom_range(0, 3), 1'b1);
                  else
                     put_raw(CH_BACKSLASH, 1'b0, 1'b1);
               end
               6: ;  // leave open, the next start abandons it
               default: begin
                  put_raw(CH_QUOTE, 1'b0, 1'b0);
                  put_raw(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
                  ignored_items++;
               end
            endcase
         end
      end
   endfunction

   task automatic offer(input raw_type r);
      if (gaps_on && !calm && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_in_byte <= r.data;
      req_start_flag <= r.start;
      req_end_of_buffer <= r.eob;
      do
         @(posedge clock);
      while (req_full);
   endtask

   initial begin
      int hold_at;
      build_directed();
      hold_at = stream.size() + 30;
      build_random();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (stream[i]) begin
         if (i == hold_at)
            hold_request = 1'b1;
         if (i >= stream.size() - CALM_TAIL)
            calm = 1'b1;
         else if ($urandom_range(0, 15) == 0)
            gaps_on = ~gaps_on;
         offer(stream[i]);
      end
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Result side: random short stalls, plus one long hold-off to back up the queue.
   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_pop <= 1'b1;
         end else if (gaps_on && !calm && $urandom_range(0, 5) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_pop <= 1'b1;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

endmodule
